// File: sv/psbe_pkg.sv
// ----------------------------------------------------------------------------
// psbe_pkg - shared types and constants
// field widths, register indexes and the tag that travels with each phase
// ----------------------------------------------------------------------------
package psbe_pkg;

  localparam int IN_W       = 18;  // gabor response, signed q10.8
  localparam int COEF_W     = 16;  // cosine / sine, signed q2.14
  localparam int FRAC_BITS  = 14;
  localparam int PROD_W     = IN_W + COEF_W;  // one coefficient product
  localparam int DIFF_W     = PROD_W + 1;     // sum of two products
  localparam int ROT_W      = 22;  // rotated term plus left term
  localparam int SQR_W      = 2 * ROT_W;
  localparam int SUM_W      = SQR_W + 1;
  localparam int ENERGY_W   = 19;
  localparam int RAD_W      = 2 * ENERGY_W;   // radicand below saturation
  localparam int ORI_W      = 3;
  localparam int PH_W       = 3;
  localparam int NUM_W      = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0]  CFG_NUM_PHASES = 4'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_COEF_BASE  = 4'd1;
  localparam logic [NUM_W-1:0]      NUM_RESET      = 3'd7;
  localparam logic [CFG_DATA_W-1:0] COEF_RESET     = 32'd16384;

  typedef struct packed {
    logic [ORI_W-1:0] ori;
    logic [PH_W-1:0]  phase;
    logic             last;
    logic             sat;
  } tag_t;

endpackage

// File: sv/phase_shift_binocular_energy.sv
// ----------------------------------------------------------------------------
// phase_shift_binocular_energy - phase-shift binocular energy unit
// rotates the right gabor pair per phase, adds the left pair and takes the
// floor square root of the squared magnitude, one result per active phase
// ----------------------------------------------------------------------------
// throughput: one result per cycle unless the output stalls; an item gives
//   num_phases results (1..7), the phase sequencer issuing one phase a cycle
//   into the pipeline and accepting the next item along with its last phase
// the whole pipeline holds while a result waits and out_ready is low
// reset: synchronous, active low; num_phases = 7, every coefficient = 16384
module phase_shift_binocular_energy #(
  parameter int NUM_PHASE_SLOTS = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psbe_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [psbe_pkg::IN_W-1:0]    in_left_even,
  input  logic signed [psbe_pkg::IN_W-1:0]    in_left_odd,
  input  logic signed [psbe_pkg::IN_W-1:0]    in_right_even,
  input  logic signed [psbe_pkg::IN_W-1:0]    in_right_odd,
  input  logic [psbe_pkg::ORI_W-1:0]          in_orientation,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [psbe_pkg::ORI_W-1:0]          out_orientation_out,
  output logic [psbe_pkg::PH_W-1:0]           out_phase_index,
  output logic [psbe_pkg::ENERGY_W-1:0]       out_energy,
  output logic                                out_last_phase
);

  localparam int SLOT_IDX_W = (NUM_PHASE_SLOTS > 1) ? $clog2(NUM_PHASE_SLOTS) : 1;
  localparam int IN_W       = psbe_pkg::IN_W;
  localparam int COEF_W     = psbe_pkg::COEF_W;
  localparam int PROD_W     = psbe_pkg::PROD_W;
  localparam int DIFF_W     = psbe_pkg::DIFF_W;
  localparam int ROT_W      = psbe_pkg::ROT_W;
  localparam int SQR_W      = psbe_pkg::SQR_W;
  localparam int SUM_W      = psbe_pkg::SUM_W;
  localparam int RAD_W      = psbe_pkg::RAD_W;
  localparam int ROOT_W     = psbe_pkg::ENERGY_W;
  localparam int TRIAL_W    = RAD_W + 2;
  localparam int PH_W       = psbe_pkg::PH_W;
  localparam int NUM_W      = psbe_pkg::NUM_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // only slots below NUM_PHASE_SLOTS can ever be read, so only those are kept
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0]                num_phases_r;
  logic [psbe_pkg::CFG_DATA_W-1:0] coef_r [NUM_PHASE_SLOTS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_phases_r <= psbe_pkg::NUM_RESET;
      for (int k = 0; k < NUM_PHASE_SLOTS; k++) begin
        coef_r[k] <= psbe_pkg::COEF_RESET;
      end
    end else if (cfg_valid) begin
      if (cfg_index == psbe_pkg::CFG_NUM_PHASES) begin
        num_phases_r <= cfg_data[NUM_W-1:0];
      end
      for (int k = 0; k < NUM_PHASE_SLOTS; k++) begin
        if (cfg_index == psbe_pkg::CFG_COEF_BASE + psbe_pkg::CFG_IDX_W'(k)) begin
          coef_r[k] <= cfg_data;
        end
      end
    end
  end

  // effective phase count: zero runs one phase, too many clamps to the slots
  logic [PH_W-1:0] count_eff;
  always_comb begin
    if (num_phases_r == '0) begin
      count_eff = PH_W'(1);
    end else if (PH_W'(num_phases_r) > PH_W'(NUM_PHASE_SLOTS)) begin
      count_eff = PH_W'(NUM_PHASE_SLOTS);
    end else begin
      count_eff = PH_W'(num_phases_r);
    end
  end

  // --------------------------------------------------------------------------
  // global advance: every stage moves unless a result sits unclaimed
  // --------------------------------------------------------------------------
  logic adv;
  assign adv = !out_valid || out_ready;

  // --------------------------------------------------------------------------
  // phase sequencer: holds the item and issues one phase per advancing cycle
  // --------------------------------------------------------------------------
  logic                    busy_r, busy_nxt;
  logic [PH_W-1:0]         ph_r, ph_nxt;
  logic [PH_W-1:0]         cnt_r;
  logic signed [IN_W-1:0]  le_r, lo_r, re_r, ro_r;
  logic [psbe_pkg::ORI_W-1:0] ori_r;
  logic                    last_issue;
  logic                    in_xfer;

  assign last_issue = (ph_r == cnt_r - PH_W'(1));
  assign in_ready   = !busy_r || (adv && last_issue);
  assign in_xfer    = in_valid && in_ready;

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
      ph_nxt   = '0;
    end else if (busy_r && adv) begin
      if (last_issue) begin
        busy_nxt = 1'b0;
      end else begin
        ph_nxt = ph_r + PH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      le_r  <= in_left_even;
      lo_r  <= in_left_odd;
      re_r  <= in_right_even;
      ro_r  <= in_right_odd;
      ori_r <= in_orientation;
      cnt_r <= count_eff;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: coefficient select and the four rotation products
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] cos_sel, sin_sel;
  logic [psbe_pkg::CFG_DATA_W-1:0] coef_sel;

  assign coef_sel = coef_r[ph_r[SLOT_IDX_W-1:0]];
  assign cos_sel  = coef_sel[psbe_pkg::CFG_DATA_W-1 -: COEF_W];
  assign sin_sel  = coef_sel[COEF_W-1:0];

  logic                     s1_valid_r;
  psbe_pkg::tag_t           s1_tag_r;
  logic signed [PROD_W-1:0] s1_cre_r, s1_sro_r, s1_cro_r, s1_sre_r;
  logic signed [IN_W-1:0]   s1_le_r, s1_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cre_r       <= cos_sel * re_r;
      s1_sro_r       <= sin_sel * ro_r;
      s1_cro_r       <= cos_sel * ro_r;
      s1_sre_r       <= sin_sel * re_r;
      s1_le_r        <= le_r;
      s1_lo_r        <= lo_r;
      s1_tag_r.ori   <= ori_r;
      s1_tag_r.phase <= ph_r;
      s1_tag_r.last  <= last_issue;
      s1_tag_r.sat   <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: combine products, floor shift (arithmetic shift), add left pair
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] rot_e, rot_o, rot_e_sh, rot_o_sh;

  assign rot_e    = DIFF_W'(s1_cre_r) - DIFF_W'(s1_sro_r);
  assign rot_o    = DIFF_W'(s1_cro_r) + DIFF_W'(s1_sre_r);
  assign rot_e_sh = rot_e >>> psbe_pkg::FRAC_BITS;
  assign rot_o_sh = rot_o >>> psbe_pkg::FRAC_BITS;

  logic                    s2_valid_r;
  psbe_pkg::tag_t          s2_tag_r;
  logic signed [ROT_W-1:0] s2_se_r, s2_so_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_se_r  <= ROT_W'(rot_e_sh) + ROT_W'(s1_le_r);
      s2_so_r  <= ROT_W'(rot_o_sh) + ROT_W'(s1_lo_r);
      s2_tag_r <= s1_tag_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: magnitudes and squares
  // --------------------------------------------------------------------------
  logic [ROT_W-1:0] abs_e, abs_o;

  assign abs_e = s2_se_r[ROT_W-1] ? ROT_W'(-s2_se_r) : ROT_W'(s2_se_r);
  assign abs_o = s2_so_r[ROT_W-1] ? ROT_W'(-s2_so_r) : ROT_W'(s2_so_r);

  logic             s3_valid_r;
  psbe_pkg::tag_t   s3_tag_r;
  logic [SQR_W-1:0] s3_sq_e_r, s3_sq_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sq_e_r <= abs_e * abs_e;
      s3_sq_o_r <= abs_o * abs_o;
      s3_tag_r  <= s2_tag_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: energy sum; anything at or above 2^38 saturates the root
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] energy_sum;
  assign energy_sum = SUM_W'(s3_sq_e_r) + SUM_W'(s3_sq_o_r);

  logic             s4_valid_r;
  psbe_pkg::tag_t   s4_tag_r;
  logic [RAD_W-1:0] s4_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_rad_r           <= energy_sum[RAD_W-1:0];
      s4_tag_r.ori       <= s3_tag_r.ori;
      s4_tag_r.phase     <= s3_tag_r.phase;
      s4_tag_r.last      <= s3_tag_r.last;
      s4_tag_r.sat       <= (energy_sum[SUM_W-1:RAD_W] != '0);
    end
  end

  // --------------------------------------------------------------------------
  // square root: one result bit per stage, msb first
  // the remainder holds radicand minus root squared so far
  // --------------------------------------------------------------------------
  logic                sq_valid_r [ROOT_W];
  psbe_pkg::tag_t      sq_tag_r   [ROOT_W];
  logic [RAD_W-1:0]    sq_rem_r   [ROOT_W];
  logic [ROOT_W-1:0]   sq_root_r  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - j;

    logic                 v_in;
    psbe_pkg::tag_t       tag_in;
    logic [RAD_W-1:0]     rem_in, rem_nxt;
    logic [ROOT_W-1:0]    root_in, root_nxt;
    logic [TRIAL_W-1:0]   trial;
    logic                 take;

    if (j == 0) begin : g_first
      assign v_in    = s4_valid_r;
      assign tag_in  = s4_tag_r;
      assign rem_in  = s4_rad_r;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sq_valid_r[j-1];
      assign tag_in  = sq_tag_r[j-1];
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
    end

    // (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k)
    assign trial = (TRIAL_W'(root_in) << (K + 1)) | (TRIAL_W'(1) << (2 * K));
    assign take  = (TRIAL_W'(rem_in) >= trial);

    always_comb begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (take) begin
        rem_nxt  = RAD_W'(TRIAL_W'(rem_in) - trial);
        root_nxt = root_in | (ROOT_W'(1) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[j] <= 1'b0;
      end else if (adv) begin
        sq_valid_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[j]  <= rem_nxt;
        sq_root_r[j] <= root_nxt;
        sq_tag_r[j]  <= tag_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result channel: last root stage is the output register
  // --------------------------------------------------------------------------
  assign out_valid           = sq_valid_r[ROOT_W-1];
  assign out_orientation_out = sq_tag_r[ROOT_W-1].ori;
  assign out_phase_index     = sq_tag_r[ROOT_W-1].phase;
  assign out_last_phase      = sq_tag_r[ROOT_W-1].last;
  assign out_energy          = sq_root_r[ROOT_W-1] | {ROOT_W{sq_tag_r[ROOT_W-1].sat}};

endmodule
